### hw/rtl/modular_arithmetic_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modular arithmetic unit.
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
// Implication that must hold at every clock edge out of reset.
`define MAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define MAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

### hw/rtl/mau_pkg.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Shared widths, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none
package mau_pkg;
  localparam int unsigned DataW = 64;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned DefaultWidth = 64;

  localparam logic [CmdW-1:0] CmdAdd = 3'd0;
  localparam logic [CmdW-1:0] CmdSub = 3'd1;
  localparam logic [CmdW-1:0] CmdMul = 3'd2;
  localparam logic [CmdW-1:0] CmdNeg = 3'd3;
  localparam logic [CmdW-1:0] CmdInv = 3'd4;
  localparam logic [CmdW-1:0] CmdExp = 3'd5;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OpNone, OpLoad, OpRedStart, OpRedStep, OpRedDone, OpAddSub, OpNeg,
    OpMulStart, OpMulStep, OpDivStart, OpDivStep, OpInvUpd, OpExpInit,
    OpExpSq, OpExpMul, OpFinish
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic       cnt_done;
    logic       a_zero;
    logic       r1_zero;
    logic       r0_one;
    logic       exp_bit;
    logic       exp_done;
  } dp_stat_t;
endpackage
`default_nettype wire

### hw/rtl/mau_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel interfaces
// Request, result and configuration channels of the modular arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
interface mau_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface mau_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_value;
  logic        inverse_ok;
  modport source (output valid, result_value, inverse_ok, input ready);
  modport sink (input valid, result_value, inverse_ok, output ready);
endinterface

interface mau_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/modular_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Channels: req (cmd, operand_a, operand_b) in, rsp (result_value,
// inverse_ok) out, and cfg carrying the modulus, all valid/ready beats.
// A request beat is accepted only while the controller is idle; one response
// beat follows each request. Both operands are first reduced by a bit-serial
// restoring divider. Add, subtract, negate and the undefined commands then
// answer straight after the reduction; multiply runs one bit-serial modular
// multiplication. Exponentiate squares once for each exponent bit and
// multiplies once more for each set bit; inverse runs one division and one
// multiplication per Euclidean step.
// One item is in work at a time: no request beat is accepted before the
// controller is back in idle.
// Reset sets the modulus to 2 and returns the controller to idle.
// A stalled response holds its payload; the next request may be accepted
// meanwhile, and its response waits until the stalled beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module modular_arithmetic_unit #(
  parameter int unsigned Width = mau_pkg::DefaultWidth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mau_req_if.sink   req,
  mau_rsp_if.source rsp,
  mau_cfg_if.sink   cfg
);
  import mau_pkg::*;
`include "modular_arithmetic_unit_assert.svh"

  logic [63:0]      mod_q;
  dp_cmd_t          dcmd;
  dp_stat_t         stat;
  logic [Width-1:0] res;
  logic             ok, busy, in_ready, out_valid;
  logic [Width-1:0] res_q;
  logic             ok_q;
  logic             mod_big, res_lt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mod_q <= 64'd2;
    else if (cfg.valid) mod_q <= cfg.data;
  end
  assign cfg.ready = 1'b1;

  mau_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_cmd_i(req.cmd), .in_ready_o(in_ready),
    .out_valid_o(out_valid), .out_ready_i(rsp.ready), .ok_o(ok), .busy_o(busy),
    .stat_i(stat), .cmd_o(dcmd)
  );

  mau_datapath #(.Width(Width)) u_dp (
    .clk_i, .rst_ni, .cmd_i(dcmd), .mod_i(mod_q[Width-1:0]),
    .a_i(req.operand_a[Width-1:0]), .b_i(req.operand_b[Width-1:0]),
    .op_i(req.cmd), .stat_o(stat), .res_o(res)
  );

  always_ff @(posedge clk_i) begin
    if (!out_valid) begin
      res_q <= res;
      ok_q  <= ok;
    end
  end

  assign req.ready = in_ready;
  assign rsp.valid = out_valid;
  assign rsp.result_value = 64'(res_q);
  assign rsp.inverse_ok = ok_q;

  assign mod_big = (mod_q[Width-1:0] >= Width'(2));
  assign res_lt  = (res_q < mod_q[Width-1:0]);

  `MAU_ASSERT_IMP(a_ready_idle, req.ready, !busy, "ready while busy")
  `MAU_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, busy, "accept did not start work")
  `MAU_ASSERT_IMP(a_res_range, rsp.valid && mod_big, res_lt, "result not below modulus")
endmodule
`default_nettype wire

### hw/rtl/mau_datapath.sv
// ----------------------------------------------------------------------------
// Modular arithmetic datapath
// Operand registers, a bit-serial reducer/divider and a bit-serial modular
// multiplier, driven one operation per cycle by the controller.
// ----------------------------------------------------------------------------
`default_nettype none
module mau_datapath #(
  parameter int unsigned Width = mau_pkg::DefaultWidth
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire mau_pkg::dp_cmd_t         cmd_i,
  input  wire logic [Width-1:0]         mod_i,
  input  wire logic [Width-1:0]         a_i,
  input  wire logic [Width-1:0]         b_i,
  input  wire logic [mau_pkg::CmdW-1:0] op_i,
  output mau_pkg::dp_stat_t             stat_o,
  output logic [Width-1:0]              res_o
);
  import mau_pkg::*;
  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width-1:0] p_q, a_q, a_d, b_q, b_d, e_q, e_d;
  logic [Width-1:0] r0_q, r0_d, r1_q, r1_d, s0_q, s0_d, s1_q, s1_d;
  logic [Width-1:0] x_q, x_d, y_q, y_d, acc_q, acc_d, rem_q, rem_d, quo_q, quo_d;
  logic [Width-1:0] res_q, res_d, src_q, src_d;
  logic [CntW-1:0]  cnt_q, cnt_d, ecnt_q, ecnt_d;
  logic [CmdW-1:0]  op_q, op_d;
  logic [Width:0]   sh, dbl, sum, pl;
  logic [Width-1:0] dbl_r, addv, ab_sum, ab_dif;

  // Shift-subtract step shared by reduction and division.
  assign sh = {rem_q, src_q[Width-1]};
  // Double-and-add step of the multiplier.
  assign dbl = {acc_q, 1'b0};
  assign dbl_r = (dbl >= {1'b0, p_q}) ? Width'(dbl - {1'b0, p_q}) : dbl[Width-1:0];
  assign addv = y_q[Width-1] ? x_q : '0;
  assign sum = {1'b0, dbl_r} + {1'b0, addv};
  assign pl = {1'b0, a_q} + {1'b0, b_q};
  assign ab_sum = (pl >= {1'b0, p_q}) ? Width'(pl - {1'b0, p_q}) : pl[Width-1:0];
  assign ab_dif = (a_q >= b_q) ? a_q - b_q : p_q - (b_q - a_q);

  always_comb begin
    a_d = a_q; b_d = b_q; e_d = e_q; r0_d = r0_q; r1_d = r1_q; s0_d = s0_q;
    s1_d = s1_q; x_d = x_q; y_d = y_q; acc_d = acc_q; rem_d = rem_q;
    quo_d = quo_q; res_d = res_q; src_d = src_q; cnt_d = cnt_q; op_d = op_q;
    ecnt_d = ecnt_q;
    unique case (cmd_i.op)
      OpLoad: begin
        a_d = a_i; b_d = b_i; e_d = b_i; op_d = op_i;
      end
      OpRedStart: begin
        src_d = cmd_i.sel[0] ? b_q : a_q; rem_d = '0; quo_d = '0;
        cnt_d = CntW'(Width);
      end
      OpDivStart: begin
        src_d = r0_q; rem_d = '0; quo_d = '0; cnt_d = CntW'(Width);
      end
      OpRedStep, OpDivStep: begin
        if (sh >= {1'b0, (cmd_i.op == OpDivStep) ? r1_q : p_q}) begin
          rem_d = Width'(sh - {1'b0, (cmd_i.op == OpDivStep) ? r1_q : p_q});
          quo_d = {quo_q[Width-2:0], 1'b1};
        end else begin
          rem_d = sh[Width-1:0];
          quo_d = {quo_q[Width-2:0], 1'b0};
        end
        src_d = src_q << 1;
        cnt_d = cnt_q - 1'b1;
      end
      OpRedDone: begin
        if (cmd_i.sel[0]) b_d = rem_q;
        else a_d = rem_q;
      end
      OpAddSub: res_d = cmd_i.sel[0] ? ab_dif : ab_sum;
      OpNeg: res_d = (a_q == '0) ? '0 : p_q - a_q;
      OpMulStart: begin
        // sel: 0 a*b, 1 res*res, 2 res*a, 3 quotient*s1
        unique case (cmd_i.sel)
          2'd0: begin x_d = a_q; y_d = b_q; end
          2'd1: begin x_d = res_q; y_d = res_q; end
          2'd2: begin x_d = a_q; y_d = res_q; end
          default: begin
            x_d = s1_q;
            y_d = (quo_q >= p_q) ? quo_q - p_q : quo_q;
          end
        endcase
        acc_d = '0; cnt_d = CntW'(Width);
      end
      OpMulStep: begin
        acc_d = (sum >= {1'b0, p_q}) ? Width'(sum - {1'b0, p_q}) : sum[Width-1:0];
        y_d = y_q << 1;
        cnt_d = cnt_q - 1'b1;
      end
      OpInvUpd: begin
        r0_d = r1_q; r1_d = rem_q; s0_d = s1_q;
        s1_d = (s0_q >= acc_q) ? s0_q - acc_q : p_q - (acc_q - s0_q);
      end
      OpExpInit: begin
        res_d = Width'(1); ecnt_d = CntW'(Width); r0_d = p_q; r1_d = a_q;
        s0_d = '0; s1_d = Width'(1);
      end
      OpExpSq: begin
        if (cmd_i.sel[0]) res_d = acc_q;
        else begin
          e_d = e_q << 1; ecnt_d = ecnt_q - 1'b1;
        end
      end
      OpExpMul: res_d = acc_q;
      OpFinish: begin
        if (cmd_i.sel[0]) res_d = '0;
        else begin
          unique case (op_q)
            CmdMul: res_d = acc_q;
            CmdInv: res_d = s0_q;
            default: res_d = res_q;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ecnt_q <= '0;
      op_q   <= '0;
      p_q    <= Width'(2);
    end else begin
      cnt_q  <= cnt_d;
      ecnt_q <= ecnt_d;
      op_q   <= op_d;
      p_q    <= (mod_i < Width'(2)) ? Width'(2) : mod_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; e_q <= e_d; r0_q <= r0_d; r1_q <= r1_d;
    s0_q <= s0_d; s1_q <= s1_d; x_q <= x_d; y_q <= y_d; acc_q <= acc_d;
    rem_q <= rem_d; quo_q <= quo_d; res_q <= res_d; src_q <= src_d;
  end

  assign stat_o.cnt_done = (cnt_q == '0);
  assign stat_o.a_zero   = (a_q == '0);
  assign stat_o.r1_zero  = (r1_q == '0);
  assign stat_o.r0_one   = (r0_q == Width'(1));
  assign stat_o.exp_bit  = e_q[Width-1];
  assign stat_o.exp_done = (ecnt_q == '0);
  assign res_o = res_q;
endmodule
`default_nettype wire

### hw/rtl/mau_ctrl.sv
// ----------------------------------------------------------------------------
// Modular arithmetic controller
// Sequences the datapath through reduction, multiplication, the extended
// Euclidean loop and square-and-multiply; it owns the req/rsp handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
module mau_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic [mau_pkg::CmdW-1:0] in_cmd_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          ok_o,
  output logic                          busy_o,
  input  wire mau_pkg::dp_stat_t        stat_i,
  output mau_pkg::dp_cmd_t              cmd_o
);
  import mau_pkg::*;
  localparam logic [4:0] SIdle = 5'd0, SRedA = 5'd1, SRedAW = 5'd2, SRedB = 5'd3,
    SRedBW = 5'd4, SDisp = 5'd5, SMul = 5'd6, SInvChk = 5'd7, SDiv = 5'd8,
    SQMul = 5'd9, SUpd = 5'd10, SExpChk = 5'd11, SSq = 5'd12, SEm = 5'd13,
    SExpShift = 5'd14, SFin = 5'd15, SOut = 5'd16;

  logic [4:0] state_q, state_d;
  logic [2:0] cmd_q, cmd_d;
  logic       ok_q, ok_d, ph_q, ph_d, valid_q, valid_d;

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; ok_d = ok_q; ph_d = ph_q; valid_d = valid_q;
    cmd_o.op = OpNone; cmd_o.sel = 2'd0;
    if (valid_q && out_ready_i) valid_d = 1'b0;
    unique case (state_q)
      SIdle: if (in_valid_i) begin
        cmd_o.op = OpLoad; cmd_d = in_cmd_i; ok_d = 1'b1; state_d = SRedA;
      end
      SRedA: begin cmd_o.op = OpRedStart; state_d = SRedAW; end
      SRedAW: begin
        if (stat_i.cnt_done) begin cmd_o.op = OpRedDone; state_d = SRedB; end
        else cmd_o.op = OpRedStep;
      end
      SRedB: begin cmd_o.op = OpRedStart; cmd_o.sel = 2'd1; state_d = SRedBW; end
      SRedBW: begin
        cmd_o.sel = 2'd1;
        if (stat_i.cnt_done) begin cmd_o.op = OpRedDone; state_d = SDisp; end
        else cmd_o.op = OpRedStep;
      end
      SDisp: begin
        unique case (cmd_q) inside
          CmdAdd, CmdSub: begin
            cmd_o.op = OpAddSub; cmd_o.sel = {1'b0, cmd_q[0]}; state_d = SOut;
          end
          CmdMul: begin cmd_o.op = OpMulStart; ph_d = 1'b0; state_d = SMul; end
          CmdNeg: begin cmd_o.op = OpNeg; state_d = SOut; end
          CmdInv: begin
            cmd_o.op = OpExpInit;
            if (stat_i.a_zero) begin ok_d = 1'b0; state_d = SFin; end
            else state_d = SInvChk;
          end
          CmdExp: begin cmd_o.op = OpExpInit; state_d = SExpChk; end
          default: begin cmd_o.op = OpFinish; cmd_o.sel = 2'd1; state_d = SOut; end
        endcase
      end
      SMul: begin
        if (stat_i.cnt_done) state_d = SFin;
        else cmd_o.op = OpMulStep;
      end
      SInvChk: begin
        if (stat_i.r1_zero) begin
          ok_d = stat_i.r0_one; state_d = SFin;
        end else begin cmd_o.op = OpDivStart; state_d = SDiv; end
      end
      SDiv: begin
        if (stat_i.cnt_done) begin
          cmd_o.op = OpMulStart; cmd_o.sel = 2'd3; state_d = SQMul;
        end else cmd_o.op = OpDivStep;
      end
      SQMul: begin
        cmd_o.sel = 2'd3;
        if (stat_i.cnt_done) state_d = SUpd;
        else cmd_o.op = OpMulStep;
      end
      SUpd: begin cmd_o.op = OpInvUpd; state_d = SInvChk; end
      SExpChk: begin
        if (stat_i.exp_done) state_d = SOut;
        else begin
          cmd_o.op = OpMulStart; cmd_o.sel = 2'd1; ph_d = 1'b0; state_d = SSq;
        end
      end
      SSq: begin
        if (!stat_i.cnt_done) cmd_o.op = OpMulStep;
        else if (!ph_q) begin
          cmd_o.op = OpExpSq; cmd_o.sel = 2'd1;
          if (stat_i.exp_bit) begin
            ph_d = 1'b1; state_d = SEm;
          end else begin
            state_d = SExpShift;
          end
        end else begin
          cmd_o.op = OpExpMul; state_d = SExpShift;
        end
      end
      SEm: begin cmd_o.op = OpMulStart; cmd_o.sel = 2'd2; state_d = SSq; end
      SExpShift: begin cmd_o.op = OpExpSq; cmd_o.sel = 2'd0; state_d = SExpChk; end
      SFin: begin
        cmd_o.op = OpFinish; cmd_o.sel = {1'b0, !ok_q}; state_d = SOut;
      end
      SOut: if (!valid_q) begin
        valid_d = 1'b1; state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; cmd_q <= '0; ok_q <= 1'b1; ph_q <= 1'b0; valid_q <= 1'b0;
    end else begin
      state_q <= state_d; cmd_q <= cmd_d; ok_q <= ok_d; ph_q <= ph_d; valid_q <= valid_d;
    end
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = valid_q;
  assign ok_o        = ok_q;
  assign busy_o      = (state_q != SIdle);
endmodule
`default_nettype wire
